@@ hw/rtl/bphl_pkg.sv @@
package bphl_pkg;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EGCD_DIV,
    ST_EGCD_UPD,
    ST_INV_FIX,
    ST_ORDER,
    ST_ZRED,
    ST_ZRED_WAIT,
    ST_BIT_INIT,
    ST_CORR_INIT,
    ST_CORR_STEP,
    ST_CORR_MUL,
    ST_CORR_APPLY,
    ST_TEST_INIT,
    ST_TEST_STEP,
    ST_TEST_MUL,
    ST_TEST_DONE,
    ST_FINAL,
    ST_FINAL_WAIT,
    ST_OUT
  } state_e;

  // Sub-steps inside a state that drives the shared unit
  typedef enum logic [1:0] {
    PH_START,
    PH_SQUARE,
    PH_MULT,
    PH_WAIT
  } phase_e;

  // Operation codes for the shared divide unit
  typedef enum logic [1:0] {
    OP_MULMOD,
    OP_DIVMOD
  } op_e;

  typedef struct packed {
    logic start;
    op_e  op;
  } unit_ctrl_t;

endpackage

@@ hw/rtl/binary_pohlig_hellman_log_unit.sv @@
// Channel | Direction | Signals
// request | in        | valid_i, stall_o, generator_i, target_i, modulus_i
// result  | out       | valid_o, stall_i, exponent_o, invalid_o
//
// One request at a time. Each multiply or reduction holds the shared divider from
// issue to result. A modulus below three is answered as invalid from the check state;
// otherwise Euclid takes up to ~1.5*MOD_WIDTH divisions and the bit walk about k*k
// multiplies. Reset clears the sequencer. stall_o is high while a request is in work
// or a result waits; a stalled result holds.
module binary_pohlig_hellman_log_unit #(
  parameter int MOD_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [31:0] generator_i,
  input  logic [31:0] target_i,
  input  logic [31:0] modulus_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [31:0] exponent_o,
  output logic        invalid_o
);

  localparam int W  = MOD_WIDTH;
  localparam int KW = $clog2(W+1);

  bphl_pkg::state_e state_q, state_d;

  logic [W-1:0] g_q, n_q, z_q, ord_q, acc_q, base_q, e_q, x_q;
  logic [W-1:0] g_d, n_d, z_d, ord_d, acc_d, base_d, e_d, x_d;
  // extended Euclid: remainders and signed cofactors
  logic [W-1:0]        r0_q, r1_q, r0_d, r1_d;
  logic signed [W+1:0] s0_q, s1_q, s0_d, s1_d;
  logic [KW-1:0] k_q, k_d, i_q, i_d;
  logic          prev_q, prev_d, inv_q, inv_d;
  bphl_pkg::phase_e phase_q, phase_d;

  logic [W-1:0]   ua, ub, ud;
  bphl_pkg::unit_ctrl_t uctrl;
  logic           udone;
  logic [2*W-1:0] uquot;
  logic [W-1:0]   urem;
  logic signed [W+1:0] sprod;
  logic signed [W+1:0] snew;

  bphl_divmod #(.W(W)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (uctrl),
    .a_i    (ua),
    .b_i    (ub),
    .d_i    (ud),
    .done_o (udone),
    .quot_o (uquot),
    .rem_o  (urem)
  );

  // Cofactor update; the true value fits W+2 bits, so a truncated product serves
  always_comb begin
    sprod = $signed(uquot[W+1:0]) * s1_q;
    snew  = s0_q - sprod;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bphl_pkg::ST_IDLE:       if (valid_i) state_d = bphl_pkg::ST_CHECK;
      bphl_pkg::ST_CHECK:      state_d = (n_q < W'(3)) ? bphl_pkg::ST_OUT
                                                       : bphl_pkg::ST_EGCD_DIV;
      bphl_pkg::ST_EGCD_DIV: begin
        if (phase_q == bphl_pkg::PH_START && r1_q == '0) state_d = bphl_pkg::ST_INV_FIX;
        else if (udone) state_d = bphl_pkg::ST_EGCD_UPD;
      end
      bphl_pkg::ST_EGCD_UPD:   state_d = bphl_pkg::ST_EGCD_DIV;
      bphl_pkg::ST_INV_FIX:    state_d = (r0_q != W'(1)) ? bphl_pkg::ST_OUT
                                                          : bphl_pkg::ST_ORDER;
      bphl_pkg::ST_ORDER:      if (ord_q <= W'(1)) state_d = bphl_pkg::ST_ZRED;
      bphl_pkg::ST_ZRED:       state_d = bphl_pkg::ST_ZRED_WAIT;
      bphl_pkg::ST_ZRED_WAIT:  if (udone) state_d = bphl_pkg::ST_TEST_INIT;
      bphl_pkg::ST_BIT_INIT:   state_d = (i_q >= k_q) ? bphl_pkg::ST_FINAL
                                                      : bphl_pkg::ST_CORR_INIT;
      bphl_pkg::ST_CORR_INIT:  state_d = bphl_pkg::ST_CORR_STEP;
      bphl_pkg::ST_CORR_STEP:  state_d = (e_q == '0) ? bphl_pkg::ST_CORR_APPLY
                                                     : bphl_pkg::ST_CORR_MUL;
      bphl_pkg::ST_CORR_MUL: begin
        if (udone && phase_q == bphl_pkg::PH_SQUARE) state_d = bphl_pkg::ST_CORR_STEP;
      end
      bphl_pkg::ST_CORR_APPLY: if (udone) state_d = bphl_pkg::ST_TEST_INIT;
      bphl_pkg::ST_TEST_INIT:  state_d = bphl_pkg::ST_TEST_STEP;
      bphl_pkg::ST_TEST_STEP:  state_d = (e_q == '0) ? bphl_pkg::ST_TEST_DONE
                                                     : bphl_pkg::ST_TEST_MUL;
      bphl_pkg::ST_TEST_MUL: begin
        if (udone && phase_q == bphl_pkg::PH_SQUARE) state_d = bphl_pkg::ST_TEST_STEP;
      end
      bphl_pkg::ST_TEST_DONE:  state_d = bphl_pkg::ST_BIT_INIT;
      bphl_pkg::ST_FINAL:      state_d = bphl_pkg::ST_FINAL_WAIT;
      bphl_pkg::ST_FINAL_WAIT: if (udone) state_d = bphl_pkg::ST_OUT;
      bphl_pkg::ST_OUT:        if (!stall_i) state_d = bphl_pkg::ST_IDLE;
      default:                 state_d = bphl_pkg::ST_IDLE;
    endcase
  end

  // Datapath control and unit requests
  always_comb begin
    g_d = g_q; n_d = n_q; z_d = z_q; ord_d = ord_q; acc_d = acc_q;
    base_d = base_q; e_d = e_q; x_d = x_q; r0_d = r0_q; r1_d = r1_q;
    s0_d = s0_q; s1_d = s1_q; k_d = k_q; i_d = i_q; prev_d = prev_q;
    inv_d = inv_q; phase_d = phase_q;
    uctrl.start = 1'b0;
    uctrl.op    = bphl_pkg::OP_DIVMOD;
    ua = '0; ub = '0; ud = n_q;
    unique case (state_q) inside
      bphl_pkg::ST_IDLE: begin
        g_d   = generator_i[W-1:0];
        z_d   = target_i[W-1:0];
        n_d   = modulus_i[W-1:0];
        inv_d = 1'b1;
        x_d   = '0;
      end
      bphl_pkg::ST_CHECK: begin
        r0_d = n_q; r1_d = g_q; s0_d = '0; s1_d = (W+2)'(1);
        phase_d = bphl_pkg::PH_START;
        ord_d = n_q - W'(1); k_d = '0;
      end
      bphl_pkg::ST_EGCD_DIV: begin
        // a generator above n costs one extra swap step, which also reduces it
        if (phase_q == bphl_pkg::PH_START && r1_q != '0) begin
          uctrl.start = 1'b1; ua = r0_q; ud = r1_q; phase_d = bphl_pkg::PH_WAIT;
        end
      end
      bphl_pkg::ST_EGCD_UPD: begin
        r0_d = r1_q; r1_d = urem; s0_d = s1_q; s1_d = snew;
        phase_d = bphl_pkg::PH_START;
      end
      bphl_pkg::ST_INV_FIX: begin
        base_d = (s0_q < 0) ? W'(s0_q + $signed({2'b0, n_q})) : W'(s0_q);
        ord_d  = n_q - W'(1);
      end
      bphl_pkg::ST_ORDER: begin
        if (ord_q > W'(1)) begin
          ord_d = ord_q >> 1; k_d = k_q + KW'(1);
        end else begin
          ord_d = n_q - W'(1);
        end
      end
      bphl_pkg::ST_ZRED: begin
        uctrl.start = 1'b1; ua = z_q; ud = n_q; i_d = '0;
      end
      bphl_pkg::ST_ZRED_WAIT: if (udone) z_d = urem;
      bphl_pkg::ST_BIT_INIT: begin
        if (i_q < k_q) begin
          e_d = (W'(prev_q)) << (i_q - KW'(1));
        end else begin
          acc_d = x_q;
        end
      end
      bphl_pkg::ST_CORR_INIT: begin
        // start the correction power from the saved inverse
        acc_d = W'(1); e_d = e_q; phase_d = bphl_pkg::PH_START;
      end
      bphl_pkg::ST_CORR_STEP, bphl_pkg::ST_TEST_STEP: phase_d = bphl_pkg::PH_START;
      bphl_pkg::ST_CORR_MUL, bphl_pkg::ST_TEST_MUL: begin
        // multiply acc by the base if the bit is set, then square the base
        if (phase_q == bphl_pkg::PH_START) begin
          if (e_q[0]) begin
            uctrl.start = 1'b1; uctrl.op = bphl_pkg::OP_MULMOD;
            ua = acc_q; ub = (state_q == bphl_pkg::ST_CORR_MUL) ? base_q : r0_q;
            phase_d = bphl_pkg::PH_MULT;
          end else begin
            uctrl.start = 1'b1; uctrl.op = bphl_pkg::OP_MULMOD;
            ua = (state_q == bphl_pkg::ST_CORR_MUL) ? base_q : r0_q; ub = ua;
            phase_d = bphl_pkg::PH_SQUARE;
          end
        end else if (phase_q == bphl_pkg::PH_MULT && udone) begin
          acc_d = urem;
          uctrl.start = 1'b1; uctrl.op = bphl_pkg::OP_MULMOD;
          ua = (state_q == bphl_pkg::ST_CORR_MUL) ? base_q : r0_q; ub = ua;
          phase_d = bphl_pkg::PH_SQUARE;
        end else if (phase_q == bphl_pkg::PH_SQUARE && udone) begin
          if (state_q == bphl_pkg::ST_CORR_MUL) base_d = urem;
          else r0_d = urem;
          e_d = e_q >> 1;
        end
      end
      bphl_pkg::ST_CORR_APPLY: begin
        if (phase_q == bphl_pkg::PH_START) begin
          uctrl.start = 1'b1; uctrl.op = bphl_pkg::OP_MULMOD;
          ua = z_q; ub = acc_q; phase_d = bphl_pkg::PH_WAIT;
        end
        if (udone) z_d = urem;
      end
      bphl_pkg::ST_TEST_INIT: begin
        // test base is z, exponent is (n-1) >> (i+1)
        acc_d = W'(1); r0_d = z_q; e_d = ord_q >> (i_q + KW'(1));
      end
      bphl_pkg::ST_TEST_DONE: begin
        prev_d = (acc_q != W'(1));
        x_d    = x_q | (W'(acc_q != W'(1)) << i_q);
        i_d    = i_q + KW'(1);
      end
      bphl_pkg::ST_FINAL: begin
        uctrl.start = 1'b1; ua = x_q; ud = ord_q;
      end
      bphl_pkg::ST_FINAL_WAIT: if (udone) begin
        x_d = urem; inv_d = 1'b0;
      end
      bphl_pkg::ST_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bphl_pkg::ST_IDLE;
      phase_q <= bphl_pkg::PH_START;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  // Inverse is kept in g_q once found, since base_q is consumed by squaring
  always_ff @(posedge clk_i) begin
    n_q <= n_d; z_q <= z_d; ord_q <= ord_d; acc_q <= acc_d; e_q <= e_d;
    x_q <= x_d; r0_q <= r0_d; r1_q <= r1_d; s0_q <= s0_d; s1_q <= s1_d;
    k_q <= k_d; i_q <= i_d; prev_q <= prev_d; inv_q <= inv_d;
    if (state_q == bphl_pkg::ST_INV_FIX) g_q <= base_d;
    else g_q <= g_d;
    if (state_q == bphl_pkg::ST_CORR_INIT) base_q <= g_q;
    else base_q <= base_d;
  end

  assign stall_o    = (state_q != bphl_pkg::ST_IDLE);
  assign valid_o    = (state_q == bphl_pkg::ST_OUT);
  assign exponent_o = inv_q ? 32'd0 : 32'(x_q);
  assign invalid_o  = inv_q;

endmodule

@@ hw/rtl/bphl_divmod.sv @@
// Shared unit: restoring divider over a 2*W-bit dividend, one quotient bit a cycle.
// OP_MULMOD first forms a*b through a WxW multiply in its load cycle.
module bphl_divmod #(
  parameter int W = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bphl_pkg::unit_ctrl_t ctrl_i,
  input  logic [W-1:0]        a_i,
  input  logic [W-1:0]        b_i,
  input  logic [W-1:0]        d_i,
  output logic                done_o,
  output logic [2*W-1:0]      quot_o,
  output logic [W-1:0]        rem_o
);

  localparam int CW = $clog2(2*W+1);

  logic [2*W-1:0] num_q, num_d;
  logic [W:0]     rem_q, rem_d;
  logic [W-1:0]   div_q, div_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           busy_q, busy_d;
  logic           done_q, done_d;
  logic [W:0]     trial;
  logic [W+1:0]   shifted;

  always_comb begin
    shifted = {rem_q, num_q[2*W-1]};
    trial   = shifted[W:0] - {1'b0, div_q};
  end

  // Load, then shift one bit per cycle
  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      if (ctrl_i.op == bphl_pkg::OP_MULMOD) begin
        num_d = {{W{1'b0}}, a_i} * {{W{1'b0}}, b_i};
      end else begin
        num_d = {{W{1'b0}}, a_i};
      end
      rem_d  = '0;
      div_d  = d_i;
      cnt_d  = CW'(2*W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (shifted[W+1] || !trial[W]) begin
        rem_d = trial;
        num_d = {num_q[2*W-2:0], 1'b1};
      end else begin
        rem_d = shifted[W:0];
        num_d = {num_q[2*W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign quot_o = num_q;
  assign rem_o  = rem_q[W-1:0];

endmodule
